### hdl/upd_pkg.sv
package upd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_ZERO    = 8'h00;

    localparam logic [7:0] BREAK_TEXT [4] = '{8'h3C, 8'h62, 8'h72, 8'h3E};
    localparam logic [1:0] BREAK_LAST = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       err;
        logic       brk;
    } t_cmd;

endpackage

### hdl/upd_front.sv
module upd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_marker,
    output logic          o_cmd_valid,
    output upd_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_PERCENT,
        MODE_DIGIT,
        MODE_DISCARD
    } t_mode;

    t_mode      r_mode;
    t_mode      n_mode;
    logic [3:0] r_nibble;
    logic [3:0] n_nibble;
    logic [4:0] hex;
    logic [7:0] data;
    logic       err;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    assign hex = hex_digit(i_in_byte);

    always_comb begin
        n_mode      = MODE_TEXT;
        n_nibble    = 4'd0;
        o_cmd_valid = 1'b0;
        data        = i_in_byte;
        err         = 1'b0;
        unique case (r_mode)
            MODE_TEXT: begin
                priority if (i_in_byte == upd_pkg::CHAR_PERCENT) begin
                    if (i_end_marker) begin
                        o_cmd_valid = 1'b1;
                        data        = upd_pkg::CHAR_ZERO;
                        err         = 1'b1;
                    end else begin
                        n_mode = MODE_PERCENT;
                    end
                end else if (i_in_byte == upd_pkg::CHAR_PLUS) begin
                    o_cmd_valid = 1'b1;
                    data        = upd_pkg::CHAR_SPACE;
                end else begin
                    o_cmd_valid = 1'b1;
                end
            end
            MODE_PERCENT: begin
                if (!hex[4]) begin
                    o_cmd_valid = 1'b1;
                    data        = upd_pkg::CHAR_ZERO;
                    err         = 1'b1;
                    n_mode      = i_end_marker ? MODE_TEXT : MODE_DISCARD;
                end else if (i_end_marker) begin
                    o_cmd_valid = 1'b1;
                    data        = {4'd0, hex[3:0]};
                end else begin
                    n_mode   = MODE_DIGIT;
                    n_nibble = hex[3:0];
                end
            end
            MODE_DIGIT: begin
                o_cmd_valid = 1'b1;
                data        = hex[4] ? {r_nibble, hex[3:0]} : {4'd0, r_nibble};
            end
            MODE_DISCARD: begin
                n_mode = i_end_marker ? MODE_TEXT : MODE_DISCARD;
            end
            default: begin
                n_mode = MODE_TEXT;
            end
        endcase
    end

    assign o_cmd.data = data;
    assign o_cmd.fin  = i_end_marker;
    assign o_cmd.err  = err;
    assign o_cmd.brk  = (data == upd_pkg::CHAR_NEWLINE) && !err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_TEXT;
            r_nibble <= 4'd0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_nibble <= n_nibble;
        end
    end

endmodule

### hdl/upd_queue.sv
module upd_queue #(
    parameter int unsigned DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  upd_pkg::t_cmd i_wr_cmd,
    input  logic          i_rd,
    output upd_pkg::t_cmd o_rd_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);
    localparam logic [PW-1:0] PTR_MAX   = PW'(DEPTH - 1);

    upd_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          wr;
    logic          rd;

    assign o_full   = (r_count == COUNT_MAX);
    assign o_empty  = (r_count == '0);
    assign wr       = i_wr && !o_full;
    assign rd       = i_rd && !o_empty;
    assign o_rd_cmd = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == PTR_MAX) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == PTR_MAX) ? '0 : r_rptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/upd_back.sv
module upd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  upd_pkg::t_cmd i_q_cmd,
    output logic          o_q_rd,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last,
    output logic          o_message_end,
    output logic          o_decode_error
);

    logic       r_valid;
    logic [1:0] r_beat;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_end;
    logic       r_err;
    logic       load;
    logic       beat_last;

    assign load      = !r_valid || i_pop;
    assign beat_last = (r_beat == upd_pkg::BREAK_LAST);
    assign o_q_rd    = load && !i_q_empty && (!i_q_cmd.brk || beat_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else if (load) begin
            r_valid <= !i_q_empty;
            if (!i_q_empty && i_q_cmd.brk) begin
                r_beat <= r_beat + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_q_empty) begin
            if (i_q_cmd.brk) begin
                r_byte <= upd_pkg::BREAK_TEXT[r_beat];
                r_last <= beat_last;
                r_end  <= beat_last && i_q_cmd.fin;
                r_err  <= 1'b0;
            end else begin
                r_byte <= i_q_cmd.data;
                r_last <= 1'b1;
                r_end  <= i_q_cmd.fin;
                r_err  <= i_q_cmd.err;
            end
        end
    end

    assign o_empty        = !r_valid;
    assign o_out_byte     = r_byte;
    assign o_run_last     = r_last;
    assign o_message_end  = r_end;
    assign o_decode_error = r_err;

    a_beat_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat != 2'd0 |-> !i_q_empty)
        else $error("break expansion in progress without a queued item");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_err |-> r_byte == upd_pkg::CHAR_ZERO && r_last)
        else $error("error result with nonzero byte or not last");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_end |-> r_last)
        else $error("string end on a result that is not last of its item");

    a_beat_mid_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(load) && $past(!i_q_empty) && $past(i_q_cmd.brk) && !$past(beat_last)
        |-> r_beat != 2'd0 && !r_last)
        else $error("break expansion ended early");

endmodule

### hdl/url_percent_decoder_top.sv
// URL percent decoder.
// Input side looks like a queue: drive in_byte and end_marker with push; the
// item is taken at a clock edge where push is high and full is low. Set
// end_marker on the final byte of each string.
// Result side looks like a queue: while empty is low the oldest result is on
// out_byte, run_last, message_end and decode_error; pop takes it.
// Each item yields zero to four results: an escape opener yields none, a
// newline yields the four bytes of "<br>", a bad escape yields one error
// result and the rest of its string is dropped.
// A result passes through the command queue and then the output register.
// Throughput: one item per cycle while full is low; the output register
// emits one result per cycle while pop is high, so a newline holds the result
// side for four results while the command queue (DEPTH entries) takes input.
// Synchronous active-low reset empties the queue and output register and
// returns the parser to plain text mode.
// When the receiver stalls, the result holds; the queue fills and full rises.
module url_percent_decoder_top #(
    parameter int unsigned DEPTH = upd_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_marker,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_message_end,
    output logic       o_decode_error
);

    logic          take;
    logic          cmd_valid;
    upd_pkg::t_cmd cmd;
    upd_pkg::t_cmd q_cmd;
    logic          q_empty;
    logic          q_rd;

    assign take = push && !full;

    upd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_in_byte    (i_in_byte),
        .i_end_marker (i_end_marker),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    upd_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (take && cmd_valid),
        .i_wr_cmd (cmd),
        .i_rd     (q_rd),
        .o_rd_cmd (q_cmd),
        .o_full   (full),
        .o_empty  (q_empty)
    );

    upd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_cmd        (q_cmd),
        .o_q_rd         (q_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_message_end  (o_message_end),
        .o_decode_error (o_decode_error)
    );

endmodule
